>>> hdl/jpeg_crop_window_aligner_assert.svh
// assertion macros shared by the crop window aligner rtl
// no dependencies; include after the module's own declarations
`ifndef JPEG_CROP_WINDOW_ALIGNER_ASSERT_SVH
`define JPEG_CROP_WINDOW_ALIGNER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JCWA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define JCWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/jcwa_pkg.sv
// shared types and constants for the crop window aligner
// no dependencies; used by the divider, the top level and the testbench
`default_nettype none

package jcwa_pkg;

   localparam int DIM_W            = 16;
   localparam int UNITS_OFS_W      = 13;
   localparam int UNITS_CNT_W      = 14;
   localparam int SAMP_W           = 3;
   localparam int MAX_SAMP         = 7;
   localparam int BLOCK_PIXELS_DEF = 8;
   localparam int DIV_STEPS        = 5;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;

   typedef enum logic [1:0] {
      OFS_UNSET = 2'd0,
      OFS_NEAR  = 2'd1,
      OFS_FAR   = 2'd2
   } ofs_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_SINGLE_COMP  = 3'd2,
      CSR_MAX_H_SAMP   = 3'd3,
      CSR_MAX_V_SAMP   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             crop_enable;
      logic [DIM_W-1:0] req_width;
      logic [DIM_W-1:0] req_height;
      logic [DIM_W-1:0] req_x_offset;
      logic [DIM_W-1:0] req_y_offset;
      logic             width_given;
      logic             height_given;
      logic [1:0]       x_offset_kind;
      logic [1:0]       y_offset_kind;
   } req_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0]       out_width;
      logic [DIM_W-1:0]       out_height;
      logic [UNITS_OFS_W-1:0] x_offset_units;
      logic [UNITS_OFS_W-1:0] y_offset_units;
      logic [UNITS_CNT_W-1:0] width_units;
      logic [UNITS_CNT_W-1:0] height_units;
      logic                   needs_copy;
      logic                   status;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> hdl/jcwa_stream_if.sv
// valid/ready channel carrying one payload of a given type
// no dependencies; specialized with the payload structs of jcwa_pkg
`default_nettype none

interface jcwa_stream_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/jcwa_div_pipe.sv
// pipelined restoring divider, up to STEPS quotient bits per stage
// depends on jcwa_pkg; stage enables come from the owner's handshake logic
`default_nettype none

module jcwa_div_pipe #(
   parameter int DVD_W = jcwa_pkg::DIM_W + 1,
   parameter int DVS_W = $clog2(jcwa_pkg::BLOCK_PIXELS_DEF * jcwa_pkg::MAX_SAMP + 1),
   parameter int STEPS = jcwa_pkg::DIV_STEPS
) (
   input  wire logic                                 clock,
   input  wire logic [(DVD_W+STEPS-1)/STEPS-1:0]     adv,
   input  wire logic [DVD_W-1:0]                     dividend,
   input  wire logic [DVS_W-1:0]                     divisor,
   output logic      [DVD_W-1:0]                     quotient,
   output logic      [DVS_W-1:0]                     remainder
);
   localparam int STAGES = (DVD_W + STEPS - 1) / STEPS;

   logic [DVS_W-1:0] rem_ff [STAGES];
   logic [DVD_W-1:0] acc_ff [STAGES];
   logic [DVS_W-1:0] rem_in [STAGES];
   logic [DVD_W-1:0] acc_in [STAGES];

   // acc shifts dividend bits out of the top and quotient bits in at the bottom
   always_comb begin
      logic [DVS_W:0]   trial;
      logic [DVS_W-1:0] rem;
      logic [DVD_W-1:0] acc;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            rem = '0;
            acc = dividend;
         end else begin
            rem = rem_ff[k-1];
            acc = acc_ff[k-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < DVD_W) begin
               trial = {rem, acc[DVD_W-1]};
               if (trial >= {1'b0, divisor}) begin
                  trial = trial - {1'b0, divisor};
                  acc   = {acc[DVD_W-2:0], 1'b1};
               end else begin
                  acc   = {acc[DVD_W-2:0], 1'b0};
               end
               rem = trial[DVS_W-1:0];
            end
         end
         rem_in[k] = rem;
         acc_in[k] = acc;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   assign quotient  = acc_ff[STAGES-1];
   assign remainder = rem_ff[STAGES-1];

endmodule

`default_nettype wire

>>> hdl/jpeg_crop_window_aligner.sv
// crop window aligner: fills crop defaults, checks the window, aligns it to iMCUs
// depends on jcwa_pkg, jcwa_stream_if, jcwa_div_pipe and the assertion header
//
// usage:
//   req_chan carries one crop request per transaction, rsp_chan one result per
//   request, in order. csr_we/csr_index/csr_wdata write the image size, the
//   single-component flag and the largest sampling factors; write them only
//   while no request is in flight.
//   with the default 16-bit dimensions the pipeline holds three stages of default
//   fill and window checks, four stages of the shared-shape restoring dividers (up
//   to five quotient bits each) and one output register. a new request is taken
//   every cycle unless back-pressure has filled every stage.
//   the iMCU split of both corners and both far edges runs in four parallel
//   dividers, so they add only one divider's depth to the pipeline.
//   when rsp_chan stalls the result holds in the output register; each stage
//   keeps its transaction and req_chan.ready drops only once every stage ahead
//   is full, so bubbles are squeezed out and nothing is lost or repeated.
//   reset empties the pipeline and returns the registers to a 1x1 image,
//   multi-component, sampling factors of one.
`default_nettype none

module jpeg_crop_window_aligner #(
   parameter int BLOCK_PIXELS = jcwa_pkg::BLOCK_PIXELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   jcwa_stream_if.sink                            req_chan,
   jcwa_stream_if.source                          rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [jcwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [jcwa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int DIM_W  = jcwa_pkg::DIM_W;
   localparam int SAMP_W = jcwa_pkg::SAMP_W;
   localparam int DVD_W  = DIM_W + 1;
   localparam int DVS_W  = $clog2(BLOCK_PIXELS * jcwa_pkg::MAX_SAMP + 1);
   localparam int STEPS  = jcwa_pkg::DIV_STEPS;
   localparam int DIV_ST = (DVD_W + STEPS - 1) / STEPS;
   localparam int DIV_0  = 3;
   localparam int OUT_ST = DIV_0 + DIV_ST;
   localparam int NST    = OUT_ST + 1;

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0]  img_w_ff, img_h_ff;
   logic              single_ff;
   logic [SAMP_W-1:0] samp_h_ff, samp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= DIM_W'(1);
         img_h_ff  <= DIM_W'(1);
         single_ff <= 1'b0;
         samp_h_ff <= SAMP_W'(1);
         samp_v_ff <= SAMP_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            jcwa_pkg::CSR_IMAGE_WIDTH:  img_w_ff  <= csr_wdata[DIM_W-1:0];
            jcwa_pkg::CSR_IMAGE_HEIGHT: img_h_ff  <= csr_wdata[DIM_W-1:0];
            jcwa_pkg::CSR_SINGLE_COMP:  single_ff <= csr_wdata[0];
            jcwa_pkg::CSR_MAX_H_SAMP:   samp_h_ff <= csr_wdata[SAMP_W-1:0];
            jcwa_pkg::CSR_MAX_V_SAMP:   samp_v_ff <= csr_wdata[SAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // iMCU edge per axis; a zero sampling factor counts as one
   logic [SAMP_W-1:0] samp_h, samp_v;
   logic [DVS_W-1:0]  imcu_w, imcu_h;

   always_comb begin
      samp_h = (samp_h_ff == '0) ? SAMP_W'(1) : samp_h_ff;
      samp_v = (samp_v_ff == '0) ? SAMP_W'(1) : samp_v_ff;
      imcu_w = single_ff ? DVS_W'(BLOCK_PIXELS) : DVS_W'(BLOCK_PIXELS) * DVS_W'(samp_h);
      imcu_h = single_ff ? DVS_W'(BLOCK_PIXELS) : DVS_W'(BLOCK_PIXELS) * DVS_W'(samp_v);
   end

   // ---------------- pipeline handshake ----------------
   logic [NST-1:0] v_ff, v_in, rdy;

   always_comb begin
      rdy[OUT_ST] = !v_ff[OUT_ST] || rsp_chan.ready;
      for (int k = OUT_ST - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in = v_ff;
      if (rdy[0]) v_in[0] = req_chan.valid;
      for (int k = 1; k < NST; k++) begin
         if (rdy[k]) v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = rdy[0];

   // ---------------- stage 0: defaults and offset range ----------------
   jcwa_pkg::req_payload_type req;
   logic [DIM_W-1:0] s0_xo_in, s0_yo_in, s0_w_in, s0_h_in;
   logic             s0_xfar_in, s0_yfar_in, s0_crop_in, s0_bad_in;
   logic [DIM_W-1:0] s0_xo_ff, s0_yo_ff, s0_w_ff, s0_h_ff;
   logic             s0_xfar_ff, s0_yfar_ff, s0_crop_ff, s0_bad_ff;

   always_comb begin
      req        = req_chan.data;
      s0_crop_in = req.crop_enable;
      s0_xo_in   = (s0_crop_in && req.x_offset_kind != jcwa_pkg::OFS_UNSET)
                   ? req.req_x_offset : '0;
      s0_yo_in   = (s0_crop_in && req.y_offset_kind != jcwa_pkg::OFS_UNSET)
                   ? req.req_y_offset : '0;
      s0_xfar_in = s0_crop_in && req.x_offset_kind == jcwa_pkg::OFS_FAR;
      s0_yfar_in = s0_crop_in && req.y_offset_kind == jcwa_pkg::OFS_FAR;
      if (!s0_crop_in) begin
         s0_w_in = img_w_ff;
         s0_h_in = img_h_ff;
      end else begin
         s0_w_in = req.width_given  ? req.req_width  : img_w_ff - s0_xo_in;
         s0_h_in = req.height_given ? req.req_height : img_h_ff - s0_yo_in;
      end
      s0_bad_in = s0_crop_in && (s0_xo_in >= img_w_ff || s0_yo_in >= img_h_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_xo_ff   <= s0_xo_in;
         s0_yo_ff   <= s0_yo_in;
         s0_w_ff    <= s0_w_in;
         s0_h_ff    <= s0_h_in;
         s0_xfar_ff <= s0_xfar_in;
         s0_yfar_ff <= s0_yfar_in;
         s0_crop_ff <= s0_crop_in;
         s0_bad_ff  <= s0_bad_in;
      end
   end

   // ---------------- stage 1: size checks, room left, far edges ----------------
   logic [DIM_W-1:0] s1_wrem_in, s1_hrem_in;
   logic [DVD_W-1:0] s1_ex0_in, s1_ey0_in;
   logic             s1_bad_in;
   logic [DIM_W-1:0] s1_xo_ff, s1_yo_ff, s1_w_ff, s1_h_ff, s1_wrem_ff, s1_hrem_ff;
   logic [DVD_W-1:0] s1_ex0_ff, s1_ey0_ff;
   logic             s1_xfar_ff, s1_yfar_ff, s1_crop_ff, s1_bad_ff;

   // right/bottom edge of the window: far kind gives it directly as image minus offset
   always_comb begin
      s1_wrem_in = img_w_ff - s0_w_ff;
      s1_hrem_in = img_h_ff - s0_h_ff;
      s1_bad_in  = s0_bad_ff || (s0_crop_ff &&
                   (s0_w_ff == '0 || s0_w_ff > img_w_ff ||
                    s0_h_ff == '0 || s0_h_ff > img_h_ff));
      s1_ex0_in  = s0_xfar_ff ? DVD_W'(img_w_ff - s0_xo_ff)
                              : DVD_W'(s0_xo_ff) + DVD_W'(s0_w_ff);
      s1_ey0_in  = s0_yfar_ff ? DVD_W'(img_h_ff - s0_yo_ff)
                              : DVD_W'(s0_yo_ff) + DVD_W'(s0_h_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_xo_ff   <= s0_xo_ff;
         s1_yo_ff   <= s0_yo_ff;
         s1_w_ff    <= s0_w_ff;
         s1_h_ff    <= s0_h_ff;
         s1_wrem_ff <= s1_wrem_in;
         s1_hrem_ff <= s1_hrem_in;
         s1_ex0_ff  <= s1_ex0_in;
         s1_ey0_ff  <= s1_ey0_in;
         s1_xfar_ff <= s0_xfar_ff;
         s1_yfar_ff <= s0_yfar_ff;
         s1_crop_ff <= s0_crop_ff;
         s1_bad_ff  <= s1_bad_in;
      end
   end

   // ---------------- stage 2: overrun check, near-edge corner, dividends ----------------
   logic [DIM_W-1:0] s2_x_in, s2_y_in;
   logic [DVD_W-1:0] s2_ex_in, s2_ey_in;
   logic             s2_bad_in;
   logic [DVD_W-1:0] s2_x_ff, s2_y_ff, s2_ex_ff, s2_ey_ff;
   logic [DIM_W-1:0] s2_w_ff, s2_h_ff;
   logic             s2_bad_ff;

   // ceil((w + x mod n) / n) equals floor((x + w + n - 1) / n) - floor(x / n)
   always_comb begin
      s2_bad_in = s1_bad_ff || (s1_crop_ff &&
                  (s1_xo_ff > s1_wrem_ff || s1_yo_ff > s1_hrem_ff));
      s2_x_in   = s1_xfar_ff ? s1_wrem_ff - s1_xo_ff : s1_xo_ff;
      s2_y_in   = s1_yfar_ff ? s1_hrem_ff - s1_yo_ff : s1_yo_ff;
      s2_ex_in  = s1_ex0_ff + DVD_W'(imcu_w - DVS_W'(1));
      s2_ey_in  = s1_ey0_ff + DVD_W'(imcu_h - DVS_W'(1));
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_x_ff   <= DVD_W'(s2_x_in);
         s2_y_ff   <= DVD_W'(s2_y_in);
         s2_ex_ff  <= s2_ex_in;
         s2_ey_ff  <= s2_ey_in;
         s2_w_ff   <= s1_w_ff;
         s2_h_ff   <= s1_h_ff;
         s2_bad_ff <= s2_bad_in;
      end
   end

   // ---------------- divider stages ----------------
   logic [DVD_W-1:0] qx, qy, qex, qey;
   logic [DVS_W-1:0] rx, ry, rex, rey;

   jcwa_div_pipe #(.DVD_W(DVD_W), .DVS_W(DVS_W), .STEPS(STEPS)) u_div_x (
      .clock     (clock),
      .adv       (rdy[DIV_0 +: DIV_ST]),
      .dividend  (s2_x_ff),
      .divisor   (imcu_w),
      .quotient  (qx),
      .remainder (rx)
   );

   jcwa_div_pipe #(.DVD_W(DVD_W), .DVS_W(DVS_W), .STEPS(STEPS)) u_div_y (
      .clock     (clock),
      .adv       (rdy[DIV_0 +: DIV_ST]),
      .dividend  (s2_y_ff),
      .divisor   (imcu_h),
      .quotient  (qy),
      .remainder (ry)
   );

   jcwa_div_pipe #(.DVD_W(DVD_W), .DVS_W(DVS_W), .STEPS(STEPS)) u_div_ex (
      .clock     (clock),
      .adv       (rdy[DIV_0 +: DIV_ST]),
      .dividend  (s2_ex_ff),
      .divisor   (imcu_w),
      .quotient  (qex),
      .remainder (rex)
   );

   jcwa_div_pipe #(.DVD_W(DVD_W), .DVS_W(DVS_W), .STEPS(STEPS)) u_div_ey (
      .clock     (clock),
      .adv       (rdy[DIV_0 +: DIV_ST]),
      .dividend  (s2_ey_ff),
      .divisor   (imcu_h),
      .quotient  (qey),
      .remainder (rey)
   );

   // window size and bad flag ride alongside the dividers
   logic [DIM_W-1:0] dv_w_ff   [DIV_ST];
   logic [DIM_W-1:0] dv_h_ff   [DIV_ST];
   logic             dv_bad_ff [DIV_ST];

   always_ff @(posedge clock) begin
      if (rdy[DIV_0]) begin
         dv_w_ff[0]   <= s2_w_ff;
         dv_h_ff[0]   <= s2_h_ff;
         dv_bad_ff[0] <= s2_bad_ff;
      end
      for (int k = 1; k < DIV_ST; k++) begin
         if (rdy[DIV_0 + k]) begin
            dv_w_ff[k]   <= dv_w_ff[k-1];
            dv_h_ff[k]   <= dv_h_ff[k-1];
            dv_bad_ff[k] <= dv_bad_ff[k-1];
         end
      end
   end

   // ---------------- output stage ----------------
   jcwa_pkg::rsp_payload_type out_in, out_ff;

   always_comb begin
      out_in = '0;
      if (dv_bad_ff[DIV_ST-1]) begin
         out_in.status = 1'b1;
      end else begin
         out_in.out_width      = dv_w_ff[DIV_ST-1] + DIM_W'(rx);
         out_in.out_height     = dv_h_ff[DIV_ST-1] + DIM_W'(ry);
         out_in.x_offset_units = jcwa_pkg::UNITS_OFS_W'(qx);
         out_in.y_offset_units = jcwa_pkg::UNITS_OFS_W'(qy);
         out_in.width_units    = jcwa_pkg::UNITS_CNT_W'(qex - qx);
         out_in.height_units   = jcwa_pkg::UNITS_CNT_W'(qey - qy);
         out_in.needs_copy     = (qx != '0) || (qy != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[OUT_ST]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = v_ff[OUT_ST];
   assign rsp_chan.data  = out_ff;

   // ---------------- assertions ----------------
`include "jpeg_crop_window_aligner_assert.svh"

   `JCWA_ASSERT_IMPLY(a_rem_below_imcu, clock, reset, v_ff[OUT_ST-1], (rx < imcu_w) && (ry < imcu_h), "divider remainder not below iMCU size")
   `JCWA_ASSERT_IMPLY(a_edge_rem_below_imcu, clock, reset, v_ff[OUT_ST-1], (rex < imcu_w) && (rey < imcu_h), "edge divider remainder not below iMCU size")
   `JCWA_ASSERT_IMPLY(a_width_in_image, clock, reset, rsp_chan.valid && !rsp_chan.data.status, rsp_chan.data.out_width <= img_w_ff, "aligned width exceeds image width")
   `JCWA_ASSERT_IMPLY(a_height_in_image, clock, reset, rsp_chan.valid && !rsp_chan.data.status, rsp_chan.data.out_height <= img_h_ff, "aligned height exceeds image height")
   `JCWA_ASSERT_IMPLY(a_bad_is_cleared, clock, reset, rsp_chan.valid && rsp_chan.data.status, (rsp_chan.data.out_width == '0) && (rsp_chan.data.width_units == '0) && !rsp_chan.data.needs_copy, "bad crop result carries data")
   `JCWA_ASSERT_NEXT(a_stalled_stage_holds, clock, reset, v_ff[DIV_0] && !rdy[DIV_0], v_ff[DIV_0], "stalled divider stage lost its transaction")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// testbench for the crop window aligner: directed and random crop requests under many image settings
// depends on jcwa_pkg, jcwa_stream_if and jpeg_crop_window_aligner; results checked in order
`timescale 1ns / 100ps

module tb_top;

   localparam int PIXEL_BLOCK     = jcwa_pkg::BLOCK_PIXELS_DEF;
   localparam int DIM_W           = jcwa_pkg::DIM_W;
   localparam int SAMP_W          = jcwa_pkg::SAMP_W;
   localparam int CSR_DATA_W      = jcwa_pkg::CSR_DATA_W;
   localparam int OFS_UNITS_W     = jcwa_pkg::UNITS_OFS_W;
   localparam int CNT_UNITS_W     = jcwa_pkg::UNITS_CNT_W;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int RANDOM_PHASES   = 9;
   localparam int CALM_PHASE      = 4;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int IDLE_PERCENT    = 13;
   localparam int DIM_MAX         = 65535;
   localparam logic [1:0] OFS_KIND_SPARE = 2'd3;

   class crop_scoreboard;
      logic [DIM_W-1:0]  img_w;
      logic [DIM_W-1:0]  img_h;
      logic              single_comp;
      logic [SAMP_W-1:0] samp_h;
      logic [SAMP_W-1:0] samp_v;
      jcwa_pkg::rsp_payload_type expected_windows[$];
      int                failures;
      int                checked;
      int                rejected;
      int                copies;

      function new();
         img_w       = 1;
         img_h       = 1;
         single_comp = 1'b0;
         samp_h      = 1;
         samp_v      = 1;
         failures    = 0;
         checked     = 0;
         rejected    = 0;
         copies      = 0;
      endfunction

      function void apply_register(jcwa_pkg::csr_index_type idx,
                                   logic [CSR_DATA_W-1:0] value);
         case (idx)
            jcwa_pkg::CSR_IMAGE_WIDTH:  img_w = value;
            jcwa_pkg::CSR_IMAGE_HEIGHT: img_h = value;
            jcwa_pkg::CSR_SINGLE_COMP:  single_comp = value[0];
            jcwa_pkg::CSR_MAX_H_SAMP:   samp_h = value[SAMP_W-1:0];
            jcwa_pkg::CSR_MAX_V_SAMP:   samp_v = value[SAMP_W-1:0];
            default: ;
         endcase
      endfunction

      // iMCU edge on one axis; a zero factor counts as one
      function longint unsigned unit_edge(logic [SAMP_W-1:0] samp);
         if (single_comp || samp == 0)
            return PIXEL_BLOCK;
         return samp * PIXEL_BLOCK;
      endfunction

      function jcwa_pkg::rsp_payload_type predict_window(jcwa_pkg::req_payload_type r);
         longint unsigned full_w, full_h, iw, ih, xo, yo, w, h, x, y, ow, oh;
         jcwa_pkg::rsp_payload_type p;
         p = '0;
         full_w = img_w;
         full_h = img_h;
         iw = unit_edge(samp_h);
         ih = unit_edge(samp_v);
         if (!r.crop_enable) begin
            ow = full_w;
            oh = full_h;
            x = 0;
            y = 0;
         end else begin
            xo = (r.x_offset_kind == jcwa_pkg::OFS_UNSET) ? 0 : r.req_x_offset;
            yo = (r.y_offset_kind == jcwa_pkg::OFS_UNSET) ? 0 : r.req_y_offset;
            if (xo >= full_w || yo >= full_h) begin
               p.status = 1'b1;
               return p;
            end
            w = r.width_given ? r.req_width : full_w - xo;
            h = r.height_given ? r.req_height : full_h - yo;
            if (w == 0 || w > full_w || h == 0 || h > full_h ||
                xo > full_w - w || yo > full_h - h) begin
               p.status = 1'b1;
               return p;
            end
            // far-edge offsets become near-edge ones
            x = (r.x_offset_kind == jcwa_pkg::OFS_FAR) ? full_w - w - xo : xo;
            y = (r.y_offset_kind == jcwa_pkg::OFS_FAR) ? full_h - h - yo : yo;
            ow = w + x % iw;
            oh = h + y % ih;
         end
         p.out_width      = DIM_W'(ow);
         p.out_height     = DIM_W'(oh);
         p.x_offset_units = OFS_UNITS_W'(x / iw);
         p.y_offset_units = OFS_UNITS_W'(y / ih);
         p.width_units    = CNT_UNITS_W'((ow + iw - 1) / iw);
         p.height_units   = CNT_UNITS_W'((oh + ih - 1) / ih);
         p.needs_copy     = (x / iw != 0) || (y / ih != 0);
         return p;
      endfunction

      function void note_request(jcwa_pkg::req_payload_type r);
         expected_windows.push_back(predict_window(r));
      endfunction

      function int pending();
         return expected_windows.size();
      endfunction

      function void match_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(jcwa_pkg::rsp_payload_type got);
         jcwa_pkg::rsp_payload_type want;
         if (expected_windows.size() == 0) begin
            failures++;
            $display("%0t: result transaction with no request outstanding", $time);
            return;
         end
         want = expected_windows.pop_front();
         checked++;
         if (want.status)
            rejected++;
         if (want.needs_copy)
            copies++;
         match_field("out_width", want.out_width, got.out_width);
         match_field("out_height", want.out_height, got.out_height);
         match_field("x_offset_units", want.x_offset_units, got.x_offset_units);
         match_field("y_offset_units", want.y_offset_units, got.y_offset_units);
         match_field("width_units", want.width_units, got.width_units);
         match_field("height_units", want.height_units, got.height_units);
         match_field("needs_copy", want.needs_copy, got.needs_copy);
         match_field("status", want.status, got.status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   jcwa_pkg::csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit calm = 1'b0;
   int settings_done = 0;
   crop_scoreboard crop_board;

   jcwa_stream_if #(.data_type(jcwa_pkg::req_payload_type)) req_if ();
   jcwa_stream_if #(.data_type(jcwa_pkg::rsp_payload_type)) rsp_if ();

   jpeg_crop_window_aligner dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random back-pressure, none during the calm phase
   always @(negedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         crop_board.check_result(rsp_if.data);
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
   end

   // edges of the range come up more often than a uniform draw gives
   function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
      int unsigned sel;
      sel = $urandom_range(7, 0);
      if (sel == 0)
         return lo;
      if (sel == 1)
         return hi;
      return $urandom_range(hi, lo);
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      int unsigned sel;
      sel = $urandom_range(15, 0);
      if (sel == 0)
         return 0;
      if (sel == 1)
         return 1;
      if (sel == 2)
         return DIM_MAX;
      if (sel < 9)
         return $urandom_range(300, 1);
      return $urandom_range(DIM_MAX, 1);
   endfunction

   // small register value, sometimes with junk above its field
   function automatic logic [CSR_DATA_W-1:0] register_word(int unsigned hi, int unsigned bits);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom_range(hi, 0);
      if ($urandom_range(3, 0) == 0)
         word = word | ($urandom << bits);
      return word;
   endfunction

   function automatic jcwa_pkg::req_payload_type crop_req(logic en, int unsigned w,
                                                          int unsigned h, int unsigned xo,
                                                          int unsigned yo,
                                                          logic wg, logic hg,
                                                          logic [1:0] xk, logic [1:0] yk);
      jcwa_pkg::req_payload_type r;
      r.crop_enable   = en;
      r.req_width     = w;
      r.req_height    = h;
      r.req_x_offset  = xo;
      r.req_y_offset  = yo;
      r.width_given   = wg;
      r.height_given  = hg;
      r.x_offset_kind = xk;
      r.y_offset_kind = yk;
      return r;
   endfunction

   // one axis of a window that fits inside the image
   function automatic void shape_axis(input int unsigned full, output logic given,
                                      output logic [1:0] kind, output logic [DIM_W-1:0] size,
                                      output logic [DIM_W-1:0] ofs);
      int unsigned sz;
      kind  = $urandom_range(3, 0);
      given = ($urandom_range(3, 0) != 0);
      size  = $urandom;
      ofs   = $urandom;
      sz    = 0;
      if (given) begin
         sz = pick_value(1, full);
         size = sz;
      end
      if (kind != jcwa_pkg::OFS_UNSET)
         ofs = given ? pick_value(0, full - sz) : pick_value(0, full - 1);
   endfunction

   // spoil one axis: offset past the edge, zero or oversize width, or overrun
   function automatic void break_axis(input int unsigned full, inout logic given,
                                      inout logic [1:0] kind, inout logic [DIM_W-1:0] size,
                                      inout logic [DIM_W-1:0] ofs);
      int unsigned v;
      case ($urandom_range(3, 0))
         0: begin
            kind = jcwa_pkg::OFS_NEAR;
            v = full + $urandom_range(2, 0);
            ofs = (v > DIM_MAX) ? DIM_MAX : v;
         end
         1: begin
            given = 1'b1;
            size = 0;
         end
         2: begin
            given = 1'b1;
            size = (full < DIM_MAX) ? full + 1 : DIM_MAX;
         end
         default: begin
            given = 1'b1;
            kind = $urandom_range(jcwa_pkg::OFS_FAR, jcwa_pkg::OFS_NEAR);
            v = pick_value(1, full);
            size = v;
            ofs = full - v + 1;
         end
      endcase
   endfunction

   function automatic jcwa_pkg::req_payload_type random_request();
      jcwa_pkg::req_payload_type r;
      int unsigned sel;
      sel = $urandom_range(99, 0);
      r.crop_enable   = $urandom;
      r.req_width     = $urandom;
      r.req_height    = $urandom;
      r.req_x_offset  = $urandom;
      r.req_y_offset  = $urandom;
      r.width_given   = $urandom;
      r.height_given  = $urandom;
      r.x_offset_kind = $urandom;
      r.y_offset_kind = $urandom;
      if (sel < 12 || crop_board.img_w == 0 || crop_board.img_h == 0)
         return r;
      r.crop_enable = (sel >= 20);
      shape_axis(crop_board.img_w, r.width_given, r.x_offset_kind, r.req_width, r.req_x_offset);
      shape_axis(crop_board.img_h, r.height_given, r.y_offset_kind, r.req_height,
                 r.req_y_offset);
      if (sel >= 20 && sel < 34) begin
         if ($urandom_range(1, 0))
            break_axis(crop_board.img_w, r.width_given, r.x_offset_kind, r.req_width,
                       r.req_x_offset);
         else
            break_axis(crop_board.img_h, r.height_given, r.y_offset_kind, r.req_height,
                       r.req_y_offset);
      end
      return r;
   endfunction

   task automatic send_request(jcwa_pkg::req_payload_type r);
      if (!calm && $urandom_range(99, 0) < IDLE_PERCENT) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      crop_board.note_request(r);
   endtask

   task automatic write_register(jcwa_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      crop_board.apply_register(idx, value);
   endtask

   // registers change only with the pipeline empty
   task automatic configure(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                            logic [CSR_DATA_W-1:0] single, logic [CSR_DATA_W-1:0] sh,
                            logic [CSR_DATA_W-1:0] sv);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (crop_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(jcwa_pkg::CSR_IMAGE_WIDTH, w);
      write_register(jcwa_pkg::CSR_IMAGE_HEIGHT, h);
      write_register(jcwa_pkg::CSR_SINGLE_COMP, single);
      write_register(jcwa_pkg::CSR_MAX_H_SAMP, sh);
      write_register(jcwa_pkg::CSR_MAX_V_SAMP, sv);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_done++;
   endtask

   initial begin
      crop_board   = new();
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = jcwa_pkg::CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: 1x1 image
      send_request(crop_req(0, 0, 0, 0, 0, 0, 0, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));
      send_request(crop_req(1, 0, 0, 0, 0, 0, 0, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));
      send_request(crop_req(1, 1, 1, 0, 0, 1, 1, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_FAR));
      send_request(crop_req(1, 0, 0, 1, 0, 0, 0, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_UNSET));
      send_request(crop_req(1, 0, 1, 0, 0, 1, 1, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));

      configure(DIM_MAX, DIM_MAX, 0, 4, 4);
      send_request(crop_req(0, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 1, 1,
                            OFS_KIND_SPARE, OFS_KIND_SPARE));
      send_request(crop_req(1, 100, 100, 0, 0, 1, 1, jcwa_pkg::OFS_FAR, jcwa_pkg::OFS_FAR));
      send_request(crop_req(1, 0, 0, DIM_MAX - 1, DIM_MAX - 1, 0, 0,
                            jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));
      send_request(crop_req(1, 1000, 1000, 12345, 54321, 1, 1,
                            OFS_KIND_SPARE, jcwa_pkg::OFS_FAR));
      send_request(crop_req(1, DIM_MAX, DIM_MAX, 0, 0, 1, 1,
                            jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));
      send_request(crop_req(1, DIM_MAX, DIM_MAX, 1, 0, 1, 1,
                            jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));
      send_request(crop_req(1, 1, 1, DIM_MAX, 0, 1, 1,
                            jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));
      send_request(crop_req(1, 1, 1, DIM_MAX - 1, DIM_MAX - 1, 1, 1,
                            jcwa_pkg::OFS_FAR, jcwa_pkg::OFS_FAR));
      send_request(crop_req(1, 5, 0, 3, 3, 1, 1, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));

      // empty image
      configure(0, 0, 0, 0, 0);
      send_request(crop_req(0, 0, 0, 0, 0, 0, 0, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));
      send_request(crop_req(1, 1, 1, 0, 0, 1, 1, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));

      // single component ignores the sampling factors
      configure(1000, 777, 1, 7, 7);
      send_request(crop_req(1, 100, 50, 13, 29, 1, 1, jcwa_pkg::OFS_FAR, jcwa_pkg::OFS_NEAR));
      send_request(crop_req(0, 0, 0, 0, 0, 0, 0, jcwa_pkg::OFS_UNSET, jcwa_pkg::OFS_UNSET));
      send_request(crop_req(1, 0, 0, 999, 776, 0, 0, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));

      configure(100, 100, 0, 7, 5);
      send_request(crop_req(1, 10, 10, 60, 41, 1, 1, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));
      configure(100, 100, 0, 0, 2);
      send_request(crop_req(1, 20, 20, 9, 17, 1, 1, jcwa_pkg::OFS_NEAR, jcwa_pkg::OFS_NEAR));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         calm = (ph == CALM_PHASE);
         case (ph)
            0: configure(DIM_MAX, DIM_MAX, 0, 4, 4);
            1: configure(1, 1, 1, 0, 0);
            default: configure(random_dim(), random_dim(), register_word(1, 1),
                               register_word(jcwa_pkg::MAX_SAMP, SAMP_W),
                               register_word(jcwa_pkg::MAX_SAMP, SAMP_W));
         endcase
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (crop_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d crop requests over %0d register settings", crop_board.checked,
               settings_done);
      $display("%0d rejected as bad crops, %0d needed a block copy", crop_board.rejected,
               crop_board.copies);
      if (crop_board.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
